### rtl/pwmf_pkg.sv
package pwmf_pkg;

   localparam int PULSE_W = 16;
   localparam int DIST_W  = 11;

   // cycles / 60 as (cycles * ceil(2^22 / 60)) >> 22, exact over 16 bits
   localparam int            RECIP_W  = 17;
   localparam logic [16:0]   CM_RECIP = 17'd69906;
   localparam int            CM_SHIFT = 22;
   localparam int            PROD_W   = PULSE_W + RECIP_W;

   localparam logic [PULSE_W-1:0] MIN_VALID_RESET = 16'd5;

   typedef struct packed {
      logic capture;    // latch the incoming pulse and its keep decision
      logic store;      // convert and write the latched pulse
      logic sort;       // one odd-even transposition pass
      logic sort_odd;   // pass works on odd pairs
      logic scan;       // run scan step on the head, rotate store
      logic scan_first; // first element of the scan
      logic finalize;   // close the last run
      logic emit;       // load result registers, clear kept count
   } pwmf_cmd_type;

endpackage

### rtl/pwmf_ctrl.sv
module pwmf_ctrl #(
   parameter int SAMPLES  = 10,
   parameter int ATTEMPTS = 25
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   output pwmf_pkg::pwmf_cmd_type cmd
);
   import pwmf_pkg::*;

   localparam int CNT_W  = $clog2(SAMPLES);
   localparam int PCNT_W = $clog2(ATTEMPTS + 1);

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_STORE = 6'b000010,
      ST_SORT  = 6'b000100,
      ST_SCAN  = 6'b001000,
      ST_FINAL = 6'b010000,
      ST_EMIT  = 6'b100000
   } state_type;

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [PCNT_W-1:0]  pulse_cnt_ff, pulse_cnt_in;
   logic               cnt_last;

   assign cnt_last = (cnt_ff == CNT_W'(SAMPLES - 1));
   assign busy     = (state_ff != ST_IDLE);

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      pulse_cnt_in = pulse_cnt_ff;
      cmd          = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               state_in    = ST_STORE;
            end
         end
         ST_STORE: begin
            cmd.store = 1'b1;
            if (pulse_cnt_ff == PCNT_W'(ATTEMPTS - 1)) begin
               pulse_cnt_in = '0;
               cnt_in       = '0;
               state_in     = ST_SORT;
            end else begin
               pulse_cnt_in = pulse_cnt_ff + 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_SORT: begin
            cmd.sort     = 1'b1;
            cmd.sort_odd = cnt_ff[0];
            if (cnt_last) begin
               cnt_in   = '0;
               state_in = ST_SCAN;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_SCAN: begin
            cmd.scan       = 1'b1;
            cmd.scan_first = (cnt_ff == '0);
            if (cnt_last) begin
               cnt_in   = '0;
               state_in = ST_FINAL;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_FINAL: begin
            cmd.finalize = 1'b1;
            state_in     = ST_EMIT;
         end
         ST_EMIT: begin
            cmd.emit = 1'b1;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         pulse_cnt_ff <= '0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         pulse_cnt_ff <= pulse_cnt_in;
      end
   end

endmodule

### rtl/pwmf_datapath.sv
module pwmf_datapath #(
   parameter int SAMPLES = 10
) (
   input  logic                                clock,
   input  logic                                reset,
   input  pwmf_pkg::pwmf_cmd_type              cmd,
   input  logic [pwmf_pkg::PULSE_W-1:0]        req_pulse_cycles,
   input  logic                                csr_wr_en,
   input  logic [pwmf_pkg::PULSE_W-1:0]        csr_wr_data,
   output logic                                rsp_strobe,
   output logic [pwmf_pkg::DIST_W-1:0]         rsp_distance_cm,
   output logic                                rsp_from_mode
);
   import pwmf_pkg::*;

   localparam int IDX_W = $clog2(SAMPLES);
   localparam int KEPT_W = $clog2(SAMPLES + 1);
   localparam int LEN_W = $clog2(SAMPLES + 1);
   localparam int MID = SAMPLES / 2;

   logic [PULSE_W-1:0] min_valid_ff;
   logic [PULSE_W-1:0] pulse_ff;
   logic               keep_ff;
   logic [KEPT_W-1:0]  kept_ff, kept_in;
   logic [DIST_W-1:0]  store_ff [SAMPLES];
   logic [DIST_W-1:0]  store_in [SAMPLES];

   logic [LEN_W-1:0]   run_len_ff, run_len_in;
   logic [DIST_W-1:0]  run_val_ff, run_val_in;
   logic [LEN_W-1:0]   best_len_ff, best_len_in;
   logic [DIST_W-1:0]  best_val_ff, best_val_in;
   logic [LEN_W-1:0]   ties_ff, ties_in;

   logic [DIST_W-1:0]  dist_ff, dist_in;
   logic               mode_ff, mode_in;
   logic               strobe_ff;

   logic [PROD_W-1:0]  product;
   logic [DIST_W-1:0]  quot;
   logic [DIST_W-1:0]  head;
   logic               close_run;
   logic               use_mode;

   assign product = PROD_W'(pulse_ff) * PROD_W'(CM_RECIP);
   assign quot    = product[CM_SHIFT +: DIST_W];
   assign head    = store_ff[0];

   // sample store: write, sort pass or rotate, one at a time
   always_comb begin
      store_in = store_ff;
      kept_in  = kept_ff;
      if (cmd.store && keep_ff) begin
         store_in[kept_ff[IDX_W-1:0]] = quot;
         kept_in = kept_ff + 1'b1;
      end else if (cmd.emit) begin
         kept_in = '0;
      end
      if (cmd.sort) begin
         for (int i = 0; i < SAMPLES - 1; i++) begin
            if (((i % 2) == 1) == cmd.sort_odd && store_ff[i] > store_ff[i+1]) begin
               store_in[i]   = store_ff[i+1];
               store_in[i+1] = store_ff[i];
            end
         end
      end
      if (cmd.scan) begin
         for (int i = 0; i < SAMPLES; i++) begin
            store_in[i] = store_ff[(i + 1) % SAMPLES];
         end
      end
   end

   // run scan over the sorted store as it rotates past position 0
   always_comb begin
      run_len_in  = run_len_ff;
      run_val_in  = run_val_ff;
      best_len_in = best_len_ff;
      best_val_in = best_val_ff;
      ties_in     = ties_ff;
      close_run   = 1'b0;
      if (cmd.scan) begin
         if (!cmd.scan_first && head == run_val_ff) begin
            run_len_in = run_len_ff + 1'b1;
         end else begin
            close_run  = !cmd.scan_first;
            run_len_in = LEN_W'(1);
            run_val_in = head;
         end
      end
      if (cmd.finalize) begin
         close_run = 1'b1;
      end
      if (cmd.scan && cmd.scan_first) begin
         best_len_in = '0;
         best_val_in = '0;
         ties_in     = '0;
      end else if (close_run) begin
         if (run_len_ff > best_len_ff) begin
            best_len_in = run_len_ff;
            best_val_in = run_val_ff;
            ties_in     = LEN_W'(1);
         end else if (run_len_ff == best_len_ff) begin
            ties_in = ties_ff + 1'b1;
         end
      end
   end

   assign use_mode = (best_len_ff >= LEN_W'(2)) && (ties_ff == LEN_W'(1)) &&
                     (best_val_ff != '0);

   always_comb begin
      dist_in = dist_ff;
      mode_in = mode_ff;
      if (cmd.emit) begin
         dist_in = use_mode ? best_val_ff : store_ff[MID];
         mode_in = use_mode;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_valid_ff <= MIN_VALID_RESET;
         kept_ff      <= '0;
         strobe_ff    <= 1'b0;
         for (int i = 0; i < SAMPLES; i++) begin
            store_ff[i] <= '0;
         end
      end else begin
         if (csr_wr_en) begin
            min_valid_ff <= csr_wr_data;
         end
         kept_ff   <= kept_in;
         strobe_ff <= cmd.emit;
         store_ff  <= store_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         pulse_ff <= req_pulse_cycles;
         keep_ff  <= (req_pulse_cycles > min_valid_ff) && (kept_ff < KEPT_W'(SAMPLES));
      end
      run_len_ff  <= run_len_in;
      run_val_ff  <= run_val_in;
      best_len_ff <= best_len_in;
      best_val_ff <= best_val_in;
      ties_ff     <= ties_in;
      dist_ff     <= dist_in;
      mode_ff     <= mode_in;
   end

   assign rsp_strobe      = strobe_ff;
   assign rsp_distance_cm = dist_ff;
   assign rsp_from_mode   = mode_ff;

endmodule

### rtl/pulse_width_mode_median_filter_top.sv
// Channel   Ports                                   Handshake
// request   req_pulse_cycles                        start high, busy low
// response  rsp_distance_cm, rsp_from_mode          rsp_strobe, one cycle
// config    csr_wr_data                             csr_wr_en
//
// A pulse is handled as capture, then the 16x17 reciprocal multiply for /60
// and the store write. The last pulse of a burst adds SAMPLES odd-even sort
// passes, SAMPLES run-scan steps, one close step and one decision step; the
// rsp_strobe register is loaded from the decision step.
// Reset clears the sample store, its counters and min_valid_cycles (to 5).
// Results cannot be held off; busy is low again in the strobe cycle.
module pulse_width_mode_median_filter_top #(
   parameter int SAMPLES  = 10,
   parameter int ATTEMPTS = 25
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [pwmf_pkg::PULSE_W-1:0]  req_pulse_cycles,
   input  logic                          csr_wr_en,
   input  logic [pwmf_pkg::PULSE_W-1:0]  csr_wr_data,
   output logic                          rsp_strobe,
   output logic [pwmf_pkg::DIST_W-1:0]   rsp_distance_cm,
   output logic                          rsp_from_mode
);
   import pwmf_pkg::*;

   pwmf_cmd_type cmd;

   pwmf_ctrl #(
      .SAMPLES  (SAMPLES),
      .ATTEMPTS (ATTEMPTS)
   ) u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .cmd   (cmd)
   );

   pwmf_datapath #(
      .SAMPLES (SAMPLES)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .req_pulse_cycles (req_pulse_cycles),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .rsp_strobe       (rsp_strobe),
      .rsp_distance_cm  (rsp_distance_cm),
      .rsp_from_mode    (rsp_from_mode)
   );

endmodule

### rtl/pwmf_checker.sv
module pwmf_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         start,
   input logic                         busy,
   input logic                         rsp_strobe,
   input logic [pwmf_pkg::DIST_W-1:0]  rsp_distance_cm,
   input logic                         rsp_from_mode
);
   import pwmf_pkg::*;

   // every accepted transaction occupies the block for its store cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("busy not raised after accepted transaction");

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe held for two cycles");

   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("result shown while block still busy");

   a_mode_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_from_mode |-> rsp_distance_cm != '0)
      else $error("mode result with zero distance");

   a_strobe_after_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_strobe) |-> $past(busy))
      else $error("result strobe without preceding work");

endmodule

bind pulse_width_mode_median_filter_top pwmf_checker u_pwmf_checker (.*);

### sim/tb_top.sv
module tb_top;
   import pwmf_pkg::*;

   localparam int SAMPLES          = 10;
   localparam int ATTEMPTS         = 25;
   localparam int DRAIN_CYCLES     = 2 * SAMPLES + 8;
   localparam int CYCLE_LIMIT      = 200000;
   localparam int NUM_PHASES       = 6;
   localparam int BURSTS_PER_PHASE = 12;
   localparam int MAX_CM           = 1092;

   typedef struct packed {
      logic [DIST_W-1:0] distance_cm;
      logic              from_mode;
   } dist_result_type;

   typedef struct packed {
      logic [PULSE_W-1:0] pulse;
      logic               typed;
      logic [DIST_W-1:0]  distance_cm;
      logic               from_mode;
   } pulse_row_type;

   typedef enum int {
      BURST_STEADY,
      BURST_SPARSE,
      BURST_ZERO,
      BURST_TIED,
      BURST_RAW
   } burst_kind_type;

   logic               clock            = 1'b0;
   logic               reset            = 1'b1;
   logic               start            = 1'b0;
   logic [PULSE_W-1:0] req_pulse_cycles = '0;
   logic               csr_wr_en        = 1'b0;
   logic [PULSE_W-1:0] csr_wr_data      = '0;
   logic               busy;
   logic               rsp_strobe;
   logic [DIST_W-1:0]  rsp_distance_cm;
   logic               rsp_from_mode;

   // filter state as the block should hold it
   logic [DIST_W-1:0]  filt_store [SAMPLES];
   int unsigned        filt_pulses;
   int unsigned        filt_kept;
   logic [PULSE_W-1:0] filt_min_valid;

   dist_result_type expected_dist_q [$];
   dist_result_type head_r;
   int           mismatches  = 0;
   int           cycle_count = 0;
   int           idle_pct    = 0;

   // first burst after reset, threshold 5: ten samples kept, the rest dropped
   pulse_row_type directed_rows [ATTEMPTS] = '{
      '{16'd0,     1'b0, 11'd0,    1'b0},   // zero width, below threshold
      '{16'd5,     1'b0, 11'd0,    1'b0},   // equal to threshold, dropped
      '{16'd6,     1'b0, 11'd0,    1'b0},   // 0 cm
      '{16'd65535, 1'b0, 11'd0,    1'b0},   // 1092 cm
      '{16'd60,    1'b0, 11'd0,    1'b0},   // 1 cm
      '{16'd119,   1'b0, 11'd0,    1'b0},   // 1 cm
      '{16'd120,   1'b0, 11'd0,    1'b0},   // 2 cm
      '{16'd65535, 1'b0, 11'd0,    1'b0},
      '{16'd65535, 1'b0, 11'd0,    1'b0},
      '{16'd600,   1'b0, 11'd0,    1'b0},   // 10 cm
      '{16'd659,   1'b0, 11'd0,    1'b0},   // 10 cm
      '{16'd6000,  1'b0, 11'd0,    1'b0},   // 100 cm, store now full
      '{16'd65535, 1'b0, 11'd0,    1'b0},
      '{16'd61,    1'b0, 11'd0,    1'b0},
      '{16'd7,     1'b0, 11'd0,    1'b0},
      '{16'd0,     1'b0, 11'd0,    1'b0},
      '{16'd5,     1'b0, 11'd0,    1'b0},
      '{16'd12345, 1'b0, 11'd0,    1'b0},
      '{16'd30000, 1'b0, 11'd0,    1'b0},
      '{16'd1,     1'b0, 11'd0,    1'b0},
      '{16'd65534, 1'b0, 11'd0,    1'b0},
      '{16'd4,     1'b0, 11'd0,    1'b0},
      '{16'd6,     1'b0, 11'd0,    1'b0},
      '{16'd100,   1'b0, 11'd0,    1'b0},
      // sorted 0 1 1 2 10 10 100 1092 1092 1092: unique run of three at 1092
      '{16'd65535, 1'b1, 11'd1092, 1'b1}
   };

   pulse_width_mode_median_filter_top #(
      .SAMPLES  (SAMPLES),
      .ATTEMPTS (ATTEMPTS)
   ) i_dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_pulse_cycles (req_pulse_cycles),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .rsp_strobe       (rsp_strobe),
      .rsp_distance_cm  (rsp_distance_cm),
      .rsp_from_mode    (rsp_from_mode)
   );

   always #10 clock = ~clock;

   task automatic reset_filter();
      for (int i = 0; i < SAMPLES; i++) filt_store[i] = '0;
      filt_pulses    = 0;
      filt_kept      = 0;
      filt_min_valid = MIN_VALID_RESET;
   endtask

   task automatic predict_pulse(input logic [PULSE_W-1:0] pulse, output bit got,
                                output dist_result_type res);
      logic [DIST_W-1:0] v;
      int                c;
      int                i;
      int                len;
      int unsigned       best_len;
      int unsigned       ties;
      logic [DIST_W-1:0] best_val;
      got = 1'b0;
      res = '0;
      if (pulse > filt_min_valid && filt_kept < SAMPLES) begin
         filt_store[filt_kept] = DIST_W'(pulse / 16'd60);
         filt_kept++;
      end
      filt_pulses++;
      if (filt_pulses < ATTEMPTS) return;
      // ascending insertion sort in place; stale slots stay sorted for next burst
      for (int a = 1; a < SAMPLES; a++) begin
         v = filt_store[a];
         c = a - 1;
         while (c >= 0 && v < filt_store[c]) begin
            filt_store[c + 1] = filt_store[c];
            c--;
         end
         filt_store[c + 1] = v;
      end
      best_len = 0;
      best_val = '0;
      ties     = 0;
      i        = 0;
      while (i < SAMPLES) begin
         len = 1;
         while (i + len < SAMPLES && filt_store[i + len] == filt_store[i]) len++;
         if (len > best_len) begin
            best_len = len;
            best_val = filt_store[i];
            ties     = 1;
         end else if (len == best_len) begin
            ties++;
         end
         i += len;
      end
      if (best_len >= 2 && ties == 1 && best_val != 0) begin
         res.distance_cm = best_val;
         res.from_mode   = 1'b1;
      end else begin
         res.distance_cm = filt_store[SAMPLES / 2];
         res.from_mode   = 1'b0;
      end
      filt_pulses = 0;
      filt_kept   = 0;
      got         = 1'b1;
   endtask

   // start is left high after acceptance so back-to-back pulses never toggle it
   task automatic send_pulse(input logic [PULSE_W-1:0] pulse);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start            <= 1'b1;
      req_pulse_cycles <= pulse;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic wait_drained();
      start <= 1'b0;
      while (expected_dist_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic logic [PULSE_W-1:0] pulse_for_cm(input int cm);
      int p;
      p = ((cm > MAX_CM) ? MAX_CM : cm) * 60 + $urandom_range(59);
      if (p > 65535) p = 65535;
      return PULSE_W'(p);
   endfunction

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("tb_top: FAIL");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (expected_dist_q.size() == 0) begin
            if (mismatches < 10)
               $display("unexpected transaction: distance_cm=%0d from_mode=%0d",
                        rsp_distance_cm, rsp_from_mode);
            mismatches++;
         end else begin
            head_r = expected_dist_q.pop_front();
            if (rsp_distance_cm !== head_r.distance_cm ||
                rsp_from_mode !== head_r.from_mode) begin
               if (mismatches < 10)
                  $display("mismatch: distance_cm exp %0d got %0d, from_mode exp %0d got %0d",
                           head_r.distance_cm, rsp_distance_cm,
                           head_r.from_mode, rsp_from_mode);
               mismatches++;
            end
         end
      end
   end

   initial begin
      logic [PULSE_W-1:0] phase_cfg [NUM_PHASES];
      logic [PULSE_W-1:0] pv;
      burst_kind_type     kind;
      int                 base;
      int                 alt;
      int                 noise_pct;
      bit                 got;
      dist_result_type    pred;

      phase_cfg = '{16'd0, 16'hFFFF, 16'd600, 16'd0, MIN_VALID_RESET, 16'd60};
      phase_cfg[3] = PULSE_W'($urandom);
      reset_filter();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      idle_pct = 27;
      foreach (directed_rows[r]) begin
         send_pulse(directed_rows[r].pulse);
         predict_pulse(directed_rows[r].pulse, got, pred);
         if (directed_rows[r].typed)
            expected_dist_q.push_back({directed_rows[r].distance_cm,
                                       directed_rows[r].from_mode});
         else if (got)
            expected_dist_q.push_back(pred);
      end

      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         wait_drained();
         csr_wr_en   <= 1'b1;
         csr_wr_data <= phase_cfg[ph];
         @(posedge clock);
         csr_wr_en      <= 1'b0;
         filt_min_valid  = phase_cfg[ph];
         idle_pct = (ph < 2) ? 27 : (ph < 4) ? 45 : 0;

         for (int b = 0; b < BURSTS_PER_PHASE; b++) begin
            kind = burst_kind_type'($urandom_range(4));
            base = ($urandom_range(3) == 0) ? $urandom_range(MAX_CM) : $urandom_range(20);
            alt  = base + 1 + $urandom_range(3);
            noise_pct = (kind == BURST_SPARSE) ? 85 : 15;
            for (int i = 0; i < ATTEMPTS; i++) begin
               // noise pulses sit at or below the threshold and are dropped
               if (kind != BURST_RAW && $urandom_range(99) < noise_pct) begin
                  pv = PULSE_W'($urandom_range(filt_min_valid));
               end else begin
                  case (kind)
                     BURST_STEADY: begin
                        pv = pulse_for_cm(($urandom_range(2) == 0) ?
                                          base + $urandom_range(2) : base);
                     end
                     BURST_SPARSE: pv = pulse_for_cm(base);
                     BURST_ZERO:   pv = pulse_for_cm(0);
                     BURST_TIED:   pv = pulse_for_cm((i % 2 == 1) ? base : alt);
                     default:      pv = PULSE_W'($urandom);
                  endcase
               end
               send_pulse(pv);
               predict_pulse(pv, got, pred);
               if (got) expected_dist_q.push_back(pred);
            end
         end
      end

      wait_drained();
      if (mismatches == 0 && expected_dist_q.size() == 0) begin
         $display("tb_top: PASS");
      end else begin
         $display("tb_top: FAIL");
      end
      $finish;
   end

endmodule

### filelist.f
rtl/pwmf_pkg.sv
rtl/pwmf_ctrl.sv
rtl/pwmf_datapath.sv
rtl/pulse_width_mode_median_filter_top.sv
rtl/pwmf_checker.sv
sim/tb_top.sv
